@@ rtl/sorted_record_table_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sorted record table checker.
// Each macro expands to one labeled concurrent assertion on i_clk,
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_RECORD_TABLE_TOP_MACROS_SVH
`define SORTED_RECORD_TABLE_TOP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SRT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/srt_pkg.sv @@
// ----------------------------------------------------------------------------
// srt_pkg
// Types and codes shared by the sorted record table modules.
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int KEY_W = 32;
    localparam int PAY_W = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LIST   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_DELETED  = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_RECORD   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op                op;
        logic signed [KEY_W-1:0] key;
        logic        [PAY_W-1:0] payload;
    } t_cell_cmd;

endpackage

@@ rtl/srt_cell.sv @@
// ----------------------------------------------------------------------------
// srt_cell
// One slot of the record chain: holds a key and payload, compares the key with
// the broadcast key and takes its own, a neighbor's, the head's or new record.
// ----------------------------------------------------------------------------
module srt_cell
    import srt_pkg::*;
(
    input  logic                    i_clk,
    input  t_cell_cmd               i_cmd,
    input  logic                    i_occ,
    input  logic                    i_wrap,
    input  logic                    i_left_mark,
    input  logic signed [KEY_W-1:0] i_left_key,
    input  logic        [PAY_W-1:0] i_left_payload,
    input  logic signed [KEY_W-1:0] i_right_key,
    input  logic        [PAY_W-1:0] i_right_payload,
    input  logic signed [KEY_W-1:0] i_head_key,
    input  logic        [PAY_W-1:0] i_head_payload,
    output logic                    o_mark,
    output logic                    o_eq,
    output logic signed [KEY_W-1:0] o_key,
    output logic        [PAY_W-1:0] o_payload
);

    logic signed [KEY_W-1:0] r_key, n_key;
    logic        [PAY_W-1:0] r_payload, n_payload;
    logic                    ge;

    assign ge     = i_occ && (r_key >= i_cmd.key);
    assign o_eq   = i_occ && (r_key == i_cmd.key);
    assign o_mark = ge || !i_occ;

    always_comb begin
        n_key     = r_key;
        n_payload = r_payload;
        case (i_cmd.op)
            CELL_INSERT: begin
                if (i_left_mark) begin
                    n_key     = i_left_key;
                    n_payload = i_left_payload;
                end else if (o_mark) begin
                    n_key     = i_cmd.key;
                    n_payload = i_cmd.payload;
                end
            end
            CELL_DELETE: begin
                if (ge) begin
                    n_key     = i_right_key;
                    n_payload = i_right_payload;
                end
            end
            CELL_ROTATE: begin
                if (i_wrap) begin
                    n_key     = i_head_key;
                    n_payload = i_head_payload;
                end else if (i_occ) begin
                    n_key     = i_right_key;
                    n_payload = i_right_payload;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
    end

    assign o_key     = r_key;
    assign o_payload = r_payload;

endmodule

@@ rtl/sorted_record_table_top.sv @@
// ----------------------------------------------------------------------------
// sorted_record_table_top
// Table of up to DEPTH records kept in ascending signed key order.
// ----------------------------------------------------------------------------
// The input channel carries one command per beat: insert, delete by key, or
// list. The output channel returns result beats; o_last_of_run marks the
// final beat caused by a command. Both channels use valid and stall.
// Records live in a chain of DEPTH cells. Every cell compares its key with
// the command key in parallel, so an insert or a delete is done in the
// cycle it is accepted and its single result beat appears in the next cycle.
// Insert and delete commands can be taken one per cycle unless a list runs
// or the output stalls. A list of n records rotates the chain once per
// output beat and gives n beats, during which the input is stalled; a list
// of an empty table gives one beat in the next cycle. Operation code three
// is dropped with no result.
// Reset empties the table and clears the output valid; no clearing pass
// over the cells is needed since only the first count cells are read.
// The result sits in an output register: while the receiver stalls, that
// beat holds and the input is stalled too, and the next command is taken in
// the same cycle the waiting beat is taken.
// ----------------------------------------------------------------------------
module sorted_record_table_top
    import srt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_operation,
    input  logic signed [KEY_W-1:0] i_search_key,
    input  logic [PAY_W-1:0]        i_payload,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [2:0]              o_status,
    output logic signed [KEY_W-1:0] o_out_key,
    output logic [PAY_W-1:0]        o_out_payload,
    output logic [CW-1:0]           o_stored_count,
    output logic                    o_last_of_run
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LIST = 2'b10
    } t_state;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [IW-1:0]           r_idx, n_idx;
    logic                    r_out_valid, n_out_valid;
    t_status                 r_status, n_status;
    logic signed [KEY_W-1:0] r_out_key, n_out_key;
    logic [PAY_W-1:0]        r_out_payload, n_out_payload;
    logic [CW-1:0]           r_out_count, n_out_count;
    logic                    r_out_last, n_out_last;

    logic                    slot_free;
    logic                    accept;
    logic                    full;
    logic                    empty;
    logic                    found;
    logic                    list_last;
    logic [CW-1:0]           count_m1;
    t_op                     op;
    t_cell_cmd               cmd;

    logic signed [KEY_W-1:0] cell_key [DEPTH];
    logic [PAY_W-1:0]        cell_pay [DEPTH];
    logic [DEPTH-1:0]        cell_mark;
    logic [DEPTH-1:0]        cell_eq;

    assign op         = t_op'(i_operation);
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !slot_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign found      = |cell_eq;
    assign count_m1   = r_count - CW'(1);
    assign list_last  = (CW'(r_idx) == count_m1);

    always_comb begin
        cmd.key     = i_search_key;
        cmd.payload = i_payload;
        cmd.op      = CELL_HOLD;
        if (accept && op == OP_INSERT && !full) begin
            cmd.op = CELL_INSERT;
        end else if (accept && op == OP_DELETE && found) begin
            cmd.op = CELL_DELETE;
        end else if (r_state == S_LIST && slot_free) begin
            cmd.op = CELL_ROTATE;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                    left_mark;
        logic signed [KEY_W-1:0] left_key;
        logic [PAY_W-1:0]        left_pay;
        logic signed [KEY_W-1:0] right_key;
        logic [PAY_W-1:0]        right_pay;

        if (g == 0) begin : g_first
            assign left_mark = 1'b0;
            assign left_key  = '0;
            assign left_pay  = '0;
        end else begin : g_inner_left
            assign left_mark = cell_mark[g-1];
            assign left_key  = cell_key[g-1];
            assign left_pay  = cell_pay[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_key = '0;
            assign right_pay = '0;
        end else begin : g_inner_right
            assign right_key = cell_key[g+1];
            assign right_pay = cell_pay[g+1];
        end

        srt_cell u_cell (
            .i_clk           (i_clk),
            .i_cmd           (cmd),
            .i_occ           (CW'(g) < r_count),
            .i_wrap          (CW'(g) == count_m1),
            .i_left_mark     (left_mark),
            .i_left_key      (left_key),
            .i_left_payload  (left_pay),
            .i_right_key     (right_key),
            .i_right_payload (right_pay),
            .i_head_key      (cell_key[0]),
            .i_head_payload  (cell_pay[0]),
            .o_mark          (cell_mark[g]),
            .o_eq            (cell_eq[g]),
            .o_key           (cell_key[g]),
            .o_payload       (cell_pay[g])
        );
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_out_valid   = r_out_valid;
        n_status      = r_status;
        n_out_key     = r_out_key;
        n_out_payload = r_out_payload;
        n_out_count   = r_out_count;
        n_out_last    = r_out_last;
        if (slot_free) begin
            n_out_valid   = 1'b0;
            n_out_key     = i_search_key;
            n_out_payload = '0;
            n_out_count   = r_count;
            n_out_last    = 1'b1;
            if (r_state == S_LIST) begin
                n_out_valid   = 1'b1;
                n_status      = ST_RECORD;
                n_out_key     = cell_key[0];
                n_out_payload = cell_pay[0];
                n_out_last    = list_last;
                n_idx         = r_idx + IW'(1);
                if (list_last) begin
                    n_state = S_IDLE;
                end
            end else if (accept) begin
                case (op)
                    OP_INSERT: begin
                        n_out_valid = 1'b1;
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status    = ST_INSERTED;
                            n_count     = r_count + CW'(1);
                            n_out_count = r_count + CW'(1);
                        end
                    end
                    OP_DELETE: begin
                        n_out_valid = 1'b1;
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else if (found) begin
                            n_status    = ST_DELETED;
                            n_count     = count_m1;
                            n_out_count = count_m1;
                        end else begin
                            n_status = ST_NOTFOUND;
                        end
                    end
                    OP_LIST: begin
                        if (empty) begin
                            n_out_valid = 1'b1;
                            n_status    = ST_EMPTY;
                            n_out_key   = '0;
                        end else begin
                            n_state = S_LIST;
                            n_idx   = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status      <= n_status;
        r_out_key     <= n_out_key;
        r_out_payload <= n_out_payload;
        r_out_count   <= n_out_count;
        r_out_last    <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_key      = r_out_key;
    assign o_out_payload  = r_out_payload;
    assign o_stored_count = r_out_count;
    assign o_last_of_run  = r_out_last;

endmodule

@@ rtl/srt_checker.sv @@
// ----------------------------------------------------------------------------
// srt_checker
// Port-level checks for the sorted record table, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_record_table_top_macros.svh"

module srt_checker
    import srt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic [1:0]              i_operation,
    input logic signed [KEY_W-1:0] i_search_key,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [2:0]              o_status,
    input logic signed [KEY_W-1:0] o_out_key,
    input logic [PAY_W-1:0]        o_out_payload,
    input logic [CW-1:0]           o_stored_count,
    input logic                    o_last_of_run
);

    `SRT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_status) && $stable(o_out_key) &&
        $stable(o_out_payload) && $stable(o_last_of_run),
        "Stalled output beat changed.")

    `SRT_ASSERT_SAME(a_backpressure, o_out_valid && i_out_stall, o_in_stall,
        "Input taken while the output beat is stalled.")

    `SRT_ASSERT_SAME(a_count_range, o_out_valid, o_stored_count <= CW'(DEPTH),
        "Stored count exceeds the table depth.")

    `SRT_ASSERT_SAME(a_single_last, o_out_valid && o_status != ST_RECORD,
        o_last_of_run, "Status beat not marked as last.")

    `SRT_ASSERT_NEXT(a_update_result,
        i_in_valid && !o_in_stall &&
        (i_operation == OP_INSERT || i_operation == OP_DELETE),
        o_out_valid && o_last_of_run && o_out_key == $past(i_search_key),
        "Insert or delete gave no result in the next cycle.")

endmodule

bind sorted_record_table_top srt_checker #(.DEPTH(DEPTH), .CW(CW)) u_srt_checker (.*);
